/* hdl/bpc_pkg.sv */
// shared types, constants and helpers for the button press classifier
package bpc_pkg;

    // width of the elapsed-time counters
    localparam int TIME_WIDTH = 16;
    // width of the millisecond configuration registers
    localparam int MS_WIDTH   = 16;
    // common width for comparing counters against register values
    localparam int CMP_WIDTH  = (TIME_WIDTH > MS_WIDTH) ? TIME_WIDTH : MS_WIDTH;

    // apb port geometry
    localparam int APB_ADDR_WIDTH = 4;
    localparam int APB_DATA_WIDTH = 32;

    typedef logic [TIME_WIDTH-1:0] time_t;
    typedef logic [MS_WIDTH-1:0]   ms_t;
    typedef logic [CMP_WIDTH-1:0]  cmp_t;

    localparam time_t TIME_MAX = {TIME_WIDTH{1'b1}};

    // register indexes, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_DEBOUNCE      = 2'd0,
        REG_LONG_PRESS    = 2'd1,
        REG_DOUBLE_WINDOW = 2'd2,
        REG_PRESS_LEVEL   = 2'd3
    } reg_idx_t;

    // register reset values
    localparam ms_t  DEBOUNCE_RESET      = ms_t'(50);
    localparam ms_t  LONG_PRESS_RESET    = '0;
    localparam ms_t  DOUBLE_WINDOW_RESET = '0;
    localparam logic PRESS_LEVEL_RESET   = 1'b0;

    // input item kinds
    localparam logic ACTION_TICK = 1'b0;
    localparam logic ACTION_EDGE = 1'b1;

    // result codes
    typedef enum logic [1:0] {
        KIND_SINGLE = 2'd0,
        KIND_DOUBLE = 2'd1,
        KIND_LONG   = 2'd2
    } press_kind_t;

    // configuration seen by the classifier
    typedef struct packed {
        ms_t  debounce_ms;
        ms_t  long_press_ms;
        ms_t  double_window_ms;
        logic press_level;
    } cfg_t;

    // one registered input item
    typedef struct packed {
        logic action;
        logic pin_level;
    } item_t;

    // result of one classification step
    typedef struct packed {
        logic        valid;
        press_kind_t kind;
    } res_t;

    // saturating increment of a time counter
    function automatic time_t sat_inc(input time_t v);
        return (v == TIME_MAX) ? v : time_t'(v + time_t'(1));
    endfunction

endpackage

/* hdl/bpc_cfg_regs.sv */
// apb configuration registers of the button press classifier
module bpc_cfg_regs (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bpc_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  logic [bpc_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic [bpc_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic                                 pready,
    output bpc_pkg::cfg_t                        cfg
);
    import bpc_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    // register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_DEBOUNCE:      cfg_next.debounce_ms      = pwdata[MS_WIDTH-1:0];
                REG_LONG_PRESS:    cfg_next.long_press_ms    = pwdata[MS_WIDTH-1:0];
                REG_DOUBLE_WINDOW: cfg_next.double_window_ms = pwdata[MS_WIDTH-1:0];
                REG_PRESS_LEVEL:   cfg_next.press_level      = pwdata[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ms      <= DEBOUNCE_RESET;
            cfg_reg.long_press_ms    <= LONG_PRESS_RESET;
            cfg_reg.double_window_ms <= DOUBLE_WINDOW_RESET;
            cfg_reg.press_level      <= PRESS_LEVEL_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // register read mux
    always_comb begin
        unique case (idx)
            REG_DEBOUNCE:      prdata = APB_DATA_WIDTH'(cfg_reg.debounce_ms);
            REG_LONG_PRESS:    prdata = APB_DATA_WIDTH'(cfg_reg.long_press_ms);
            REG_DOUBLE_WINDOW: prdata = APB_DATA_WIDTH'(cfg_reg.double_window_ms);
            REG_PRESS_LEVEL:   prdata = APB_DATA_WIDTH'(cfg_reg.press_level);
            default:           prdata = '0;
        endcase
    end

endmodule

/* hdl/bpc_in_reg.sv */
// input register stage of the button press classifier
module bpc_in_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  bpc_pkg::item_t s_item,
    input  logic           advance,
    output logic           item_valid,
    output bpc_pkg::item_t item
);
    import bpc_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    logic  accept;

    // take a new item when empty or when the held one moves on
    assign s_tready   = !valid_reg || advance;
    assign accept     = s_tvalid && s_tready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_item;
        end
    end

endmodule

/* hdl/bpc_classify.sv */
// press classification state and next-state logic
module bpc_classify (
    input  logic           aclk,
    input  logic           aresetn,
    input  bpc_pkg::cfg_t  cfg,
    input  logic           step,
    input  bpc_pkg::item_t item,
    output bpc_pkg::res_t  res
);
    import bpc_pkg::*;

    time_t since_edge_reg,    since_edge_next;
    time_t since_press_reg,   since_press_next;
    logic  press_pending_reg, press_pending_next;
    ms_t   window_left_reg,   window_left_next;
    logic  window_armed_reg,  window_armed_next;

    logic  bounced;
    logic  is_long;

    // edge filter and long-press test
    assign bounced = cmp_t'(since_edge_reg) < cmp_t'(cfg.debounce_ms);
    assign is_long = (cfg.long_press_ms != '0) &&
                     (cmp_t'(since_press_reg) > cmp_t'(cfg.long_press_ms));

    // one step of the classifier
    always_comb begin
        since_edge_next    = since_edge_reg;
        since_press_next   = since_press_reg;
        press_pending_next = press_pending_reg;
        window_left_next   = window_left_reg;
        window_armed_next  = window_armed_reg;
        res.valid          = 1'b0;
        res.kind           = KIND_SINGLE;

        if (step) begin
            if (item.action == ACTION_TICK) begin
                // tick: advance counters, run the double-press window
                since_edge_next  = sat_inc(since_edge_reg);
                since_press_next = sat_inc(since_press_reg);
                if (window_armed_reg) begin
                    if (window_left_reg <= ms_t'(1)) begin
                        window_left_next   = '0;
                        window_armed_next  = 1'b0;
                        press_pending_next = 1'b0;
                        res.valid          = 1'b1;
                        res.kind           = KIND_SINGLE;
                    end else begin
                        window_left_next = window_left_reg - ms_t'(1);
                    end
                end
            end else if (!bounced) begin
                // accepted pin edge
                since_edge_next = '0;
                if (item.pin_level == cfg.press_level) begin
                    since_press_next = '0;
                end else if (is_long) begin
                    press_pending_next = 1'b0;
                    res.valid          = 1'b1;
                    res.kind           = KIND_LONG;
                end else if (press_pending_reg) begin
                    press_pending_next = 1'b0;
                    window_armed_next  = 1'b0;
                    window_left_next   = '0;
                    res.valid          = 1'b1;
                    res.kind           = KIND_DOUBLE;
                end else if (cfg.double_window_ms != '0) begin
                    press_pending_next = 1'b1;
                    window_left_next   = cfg.double_window_ms;
                    window_armed_next  = 1'b1;
                end else begin
                    res.valid = 1'b1;
                    res.kind  = KIND_SINGLE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            since_edge_reg    <= '0;
            since_press_reg   <= '0;
            press_pending_reg <= 1'b0;
            window_left_reg   <= '0;
            window_armed_reg  <= 1'b0;
        end else begin
            since_edge_reg    <= since_edge_next;
            since_press_reg   <= since_press_next;
            press_pending_reg <= press_pending_next;
            window_left_reg   <= window_left_next;
            window_armed_reg  <= window_armed_next;
        end
    end

endmodule

/* hdl/bpc_out_reg.sv */
// result register of the button press classifier
module bpc_out_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  bpc_pkg::res_t       res,
    output logic                free,
    output logic                m_tvalid,
    input  logic                m_tready,
    output bpc_pkg::press_kind_t kind
);
    import bpc_pkg::*;

    logic        valid_reg;
    press_kind_t kind_reg;

    // slot is free when empty or drained this cycle
    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign kind     = kind_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= res.valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (free && res.valid) begin
            kind_reg <= res.kind;
        end
    end

endmodule

/* hdl/button_press_classifier_core.sv */
// top level of the button press classifier
//
// Input stream: one item per transfer. s_tuser[0] is the action (0 one
// millisecond tick, 1 pin edge), s_tdata[0] the sampled pin level.
// Output stream: one transfer per classified press, m_tdata[1:0] holds the
// press kind (0 single, 1 double, 2 long). Ticks and edges that finish no
// press give no transfer.
// Configuration: apb registers debounce_ms at 0x0, long_press_ms at 0x4,
// double_window_ms at 0x8, press_level at 0xc; write only while idle.
// Timing: an item waits in the input register until the result register
// is free; then the state update and the result register are written at
// the same clock edge, and the result shows on m_tvalid. One item per
// cycle is sustained while the result register is free.
// A stalled receiver holds the result register; the input register still
// drains items that give no result only while that register is free, so
// s_tready drops once both stages are full.
// Reset (aresetn low, synchronous) clears all counters, the pending press,
// the window and both stages, and restores the register defaults.
module button_press_classifier_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,  // [0] pin_level
    input  logic [0:0]                          s_tuser,  // [0] action
    // result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,  // [1:0] press_kind
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bpc_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [bpc_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [bpc_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                pready
);
    import bpc_pkg::*;

    cfg_t        cfg;
    item_t       s_item;
    item_t       item;
    logic        item_valid;
    logic        out_free;
    logic        step;
    res_t        res;
    press_kind_t kind;

    assign s_item.action    = s_tuser[0];
    assign s_item.pin_level = s_tdata[0];

    // held item moves on once the result slot can take its outcome
    assign step = item_valid && out_free;

    assign m_tdata = {6'b0, kind};

    bpc_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bpc_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (step),
        .item_valid (item_valid),
        .item       (item)
    );

    bpc_classify u_classify (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step    (step),
        .item    (item),
        .res     (res)
    );

    bpc_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .kind     (kind)
    );

endmodule
